FILE: rtl/lis_pkg.sv
// shared constants for the indexed lifo stack: field widths, default depth, command and status codes
// no dependencies
package lis_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 8;
    localparam int CMD_W     = 3;
    localparam int ST_W      = 2;
    localparam int DEPTH_DEF = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CHANGE  = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_OVER   = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDER  = 2'd2;
    localparam logic [ST_W-1:0] ST_BADIDX = 2'd3;

endpackage

FILE: rtl/lis_mem.sv
// entry store of the stack: one write port, one read port, registered read data
// depends on lis_pkg
module lis_mem #(
    parameter int DEPTH = lis_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [lis_pkg::DATA_W-1:0] i_wdata,
    input  logic                              i_re,
    input  logic [AW-1:0]                     i_raddr,
    output logic signed [lis_pkg::DATA_W-1:0] o_rdata
);

    logic signed [lis_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [lis_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/indexed_lifo_stack_core.sv
// push, change and every error beat appear in the cycle after the input beat; pop and peep
// pass through the memory read register, then the output register; display gives its first
// beat the same way, then one per cycle while the result channel is ready; push and change
// take one input beat per cycle while it is ready; after a pop, peep or display no beat is
// taken until its last result is loaded; reset: synchronous, active low; clears the count
// and the output valid flag, entries stay undefined until pushed (no clearing pass)
module indexed_lifo_stack_core #(
    parameter int DEPTH = lis_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [lis_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [lis_pkg::DATA_W-1:0] i_value,
    input  logic [lis_pkg::IDX_W-1:0]         i_index,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [lis_pkg::DATA_W-1:0] o_data,
    output logic [lis_pkg::ST_W-1:0]          o_status,
    output logic                              o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic [0:0] S_IDLE = 1'b0;  // waiting for an input beat
    localparam logic [0:0] S_RD   = 1'b1;  // memory read in flight or read data waiting

    logic [0:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos,   n_pos;     // display walk position
    logic          r_disp,  n_disp;    // current read belongs to a display

    // output register
    logic                              r_out_valid;
    logic signed [lis_pkg::DATA_W-1:0] r_data;
    logic [lis_pkg::ST_W-1:0]          r_status;
    logic                              r_last;

    // memory ports
    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic signed [lis_pkg::DATA_W-1:0] mem_wdata;
    logic                              mem_re;
    logic [AW-1:0]                     mem_raddr;
    logic signed [lis_pkg::DATA_W-1:0] mem_rdata;

    // result load into the output register
    logic                              ld;
    logic signed [lis_pkg::DATA_W-1:0] ld_data;
    logic [lis_pkg::ST_W-1:0]          ld_status;
    logic                              ld_last;

    logic          acc;
    logic          slot_free;
    logic          full;
    logic          empty;
    logic          idx_ok;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] idx_addr;

    lis_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // the output slot is free when empty or being drained this cycle
    assign slot_free = !r_out_valid || i_ready;
    // one item at a time; a new beat is taken only when its immediate result has room,
    // so a read and a write to the memory never fall on the same edge
    assign o_ready   = (r_state == S_IDLE) && slot_free;
    assign acc       = i_valid && o_ready;

    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);
    // position 1 is the top entry, position count the bottom one
    assign idx_ok   = (i_index != '0) && (i_index <= lis_pkg::IDX_W'(r_count));
    assign top_addr = AW'(r_count - CW'(1));
    assign idx_addr = AW'(r_count - CW'(i_index));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_disp    = r_disp;
        mem_we    = 1'b0;
        mem_waddr = AW'(r_count);
        mem_wdata = i_value;
        mem_re    = 1'b0;
        mem_raddr = top_addr;
        ld        = 1'b0;
        ld_data   = '0;
        ld_status = lis_pkg::ST_OK;
        ld_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (i_cmd)
                        lis_pkg::CMD_PUSH: begin
                            ld = 1'b1;
                            if (full) begin
                                ld_status = lis_pkg::ST_OVER;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        lis_pkg::CMD_POP: begin
                            if (empty) begin
                                ld        = 1'b1;
                                ld_status = lis_pkg::ST_UNDER;
                            end else begin
                                n_count = r_count - CW'(1);
                                mem_re  = 1'b1;
                                n_disp  = 1'b0;
                                n_state = S_RD;
                            end
                        end
                        lis_pkg::CMD_DISPLAY: begin
                            if (empty) begin
                                ld        = 1'b1;
                                ld_status = lis_pkg::ST_UNDER;
                            end else begin
                                mem_re  = 1'b1;
                                n_pos   = top_addr;
                                n_disp  = 1'b1;
                                n_state = S_RD;
                            end
                        end
                        lis_pkg::CMD_PEEP: begin
                            if (!idx_ok) begin
                                ld        = 1'b1;
                                ld_status = lis_pkg::ST_BADIDX;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = idx_addr;
                                n_disp    = 1'b0;
                                n_state   = S_RD;
                            end
                        end
                        lis_pkg::CMD_CHANGE: begin
                            ld = 1'b1;
                            if (!idx_ok) begin
                                ld_status = lis_pkg::ST_BADIDX;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = idx_addr;
                            end
                        end
                        default: begin
                            // unknown command: no result, no state change
                        end
                    endcase
                end
            end
            S_RD: begin
                // read data is held by the memory until the slot frees up
                if (slot_free) begin
                    ld      = 1'b1;
                    ld_data = mem_rdata;
                    ld_last = !r_disp || (r_pos == '0);
                    if (r_disp && (r_pos != '0)) begin
                        // next entry down, one beat per cycle while the output slot is free
                        mem_re    = 1'b1;
                        mem_raddr = r_pos - AW'(1);
                        n_pos     = r_pos - AW'(1);
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_disp <= n_disp;
        if (ld) begin
            r_data   <= ld_data;
            r_status <= ld_status;
            r_last   <= ld_last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_data   = r_data;
    assign o_status = r_status;
    assign o_last   = r_last;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("stack count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_cmd == lis_pkg::CMD_PUSH) && !full)
        |=> (r_count == $past(r_count) + CW'(1)) && o_valid)
        else $error("push did not grow the stack");

    a_pop_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_cmd == lis_pkg::CMD_POP) && !empty)
        |=> (r_count == $past(r_count) - CW'(1)) && (r_state == S_RD))
        else $error("pop did not shrink the stack and start a read");

    a_no_write_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> !mem_we)
        else $error("memory write during a read sequence");

    a_no_load_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld |-> slot_free)
        else $error("result loaded over a waiting beat");
`endif

endmodule
